FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tpimt_pkg.sv
// ----------------------------------------------------------------------------
// tpimt_pkg
// Shared constants, codes and color expansion for the icon texel writer.
// ----------------------------------------------------------------------------
package tpimt_pkg;

	localparam int ICON_SIZE_DEF = 32;
	localparam int TEX_SIZE_DEF  = 64;

	localparam int PAL_DEPTH = 16;
	localparam int IDX_W     = 4;
	localparam int COLOR_W   = 15;
	localparam int PAIR_W    = 8;
	localparam int ADDR_W    = 12;
	localparam int RGBA_W    = 32;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;

	typedef enum logic {
		CMD_PALETTE = 1'b0,
		CMD_PIXELS  = 1'b1
	} cmd_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [RGBA_W-1:0] RGBA_CLEAR = 32'h00000000;

	// BGR555 -> RGBA8888, each channel shifted up by 3
	function automatic logic [RGBA_W-1:0] expand_color(input logic [COLOR_W-1:0] c);
		return {c[4:0], 3'b000, c[9:5], 3'b000, c[14:10], 3'b000, ALPHA_OPAQUE};
	endfunction

endpackage

FILE: sv/tpimt_ram.sv
// ----------------------------------------------------------------------------
// tpimt_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tpimt_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

FILE: sv/tiled_palette_icon_to_morton_texels.sv
// ----------------------------------------------------------------------------
// tiled_palette_icon_to_morton_texels
// Converts a tiled 4bpp paletted icon into Morton-ordered RGBA8888 texels.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the beat kind. A palette beat writes one
// 16-entry palette slot and produces nothing. A pixel beat carries one icon
// byte (two pixels, low nibble first) and produces two output beats: the
// left texel (tlast = 0) then the right texel (tlast = 1). tuser on the
// output flags the right texel of the icon's last byte; the byte counter
// then wraps and the next pixel beat starts a new icon.
// A pixel beat loads the palette read register and the pair stage as it
// is accepted, then the output register, from which its left texel is
// taken; the right texel follows if the receiver keeps tready high. The
// single output port moves one texel per cycle while the receiver keeps
// tready high, and a new pixel beat is taken as the previous one's right
// texel moves from the pair stage into the output register.
// A stalled receiver holds the output register; the pair stage behind it
// fills and tready on the input drops until the pair drains.
// Reset clears the byte counter and all valid flags; palette contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tiled_palette_icon_to_morton_texels
	import tpimt_pkg::*;
#(
	parameter int ICON_SIZE = ICON_SIZE_DEF,
	parameter int TEX_SIZE  = TEX_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] entry_index, [18:4] entry_color, [26:19] pixel_pair, [31:27] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] cmd
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [11:0] texel_address, [43:12] texel_color, [47:44] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// last
	output logic                  m_axis_tlast,
	// [0] icon_done
	output logic                  m_axis_tuser
);

	localparam int TILES_X     = ICON_SIZE / 8;
	localparam int ICON_BYTES  = (ICON_SIZE * ICON_SIZE) / 2;
	localparam int CW          = $clog2(ICON_BYTES);
	localparam int TILES       = (ICON_BYTES + 31) / 32;
	localparam int TILE_ROWS   = (TILES + TILES_X - 1) / TILES_X;
	localparam int TXW         = (TILES_X > 1) ? $clog2(TILES_X) : 1;
	localparam int TYW         = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int TEX_TILES_X = TEX_SIZE / 8;
	localparam int DW          = TYW + $clog2(TEX_TILES_X) + 1;

	// input fields
	logic [IDX_W-1:0]   entry_index;
	logic [COLOR_W-1:0] entry_color;
	logic [PAIR_W-1:0]  pixel_pair;
	cmd_t               cmd;

	assign entry_index = s_axis_tdata[3:0];
	assign entry_color = s_axis_tdata[18:4];
	assign pixel_pair  = s_axis_tdata[26:19];
	assign cmd         = cmd_t'(s_axis_tuser);

	logic in_take, pal_wr, byte_take;
	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign pal_wr    = in_take && (cmd == CMD_PALETTE);
	assign byte_take = in_take && (cmd == CMD_PIXELS);

	// palette, read at both nibbles as the byte is accepted
	logic [COLOR_W-1:0] pal_rd_lo, pal_rd_hi;

	tpimt_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PAL_DEPTH)
	) u_palette (
		.clk     (clk),
		.we      (pal_wr),
		.waddr   (entry_index),
		.wdata   (entry_color),
		.re      (byte_take),
		.raddr_a (pixel_pair[3:0]),
		.raddr_b (pixel_pair[7:4]),
		.rdata_a (pal_rd_lo),
		.rdata_b (pal_rd_hi)
	);

	// byte position: cnt_q counts bytes, tile_x_q / tile_y_q track the tile
	logic [CW-1:0]  cnt_q;
	logic [TXW-1:0] tile_x_q;
	logic [TYW-1:0] tile_y_q;
	logic           final_byte;
	logic [DW-1:0]  tex_tile;
	logic [ADDR_W-1:0] base_addr;

	assign final_byte = (cnt_q == CW'(ICON_BYTES - 1));
	assign tex_tile   = DW'(tile_y_q) * DW'(TEX_TILES_X) + DW'(tile_x_q);
	// Morton: y2 x2 y1 x1 y0 x0, x0 is the pixel within the pair
	assign base_addr  = ADDR_W'({tex_tile, cnt_q[4], cnt_q[1], cnt_q[3], cnt_q[0],
		cnt_q[2], 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tile_x_q <= '0;
			tile_y_q <= '0;
		end else if (byte_take) begin
			if (final_byte) begin
				cnt_q    <= '0;
				tile_x_q <= '0;
				tile_y_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q[4:0] == 5'h1F) begin
					if (tile_x_q == TXW'(TILES_X - 1)) begin
						tile_x_q <= '0;
						tile_y_q <= tile_y_q + 1'b1;
					end else begin
						tile_x_q <= tile_x_q + 1'b1;
					end
				end
			end
		end
	end

	// pair stage: one accepted byte, drained as two texels
	logic              valid_s1, sel_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              zero_lo_s1, zero_hi_s1, final_s1;

	// output register
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [RGBA_W-1:0] out_color_q;
	logic              out_last_q, out_done_q;

	logic out_load, pair_done;
	assign out_load  = valid_s1 && (!out_valid_q || m_axis_tready);
	assign pair_done = out_load && sel_s1;

	assign s_axis_tready = !valid_s1 || pair_done;

	logic [RGBA_W-1:0] texel_color;
	always_comb begin
		if (sel_s1) begin
			texel_color = zero_hi_s1 ? RGBA_CLEAR : expand_color(pal_rd_hi);
		end else begin
			texel_color = zero_lo_s1 ? RGBA_CLEAR : expand_color(pal_rd_lo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sel_s1   <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
			sel_s1   <= 1'b0;
		end else if (pair_done) begin
			valid_s1 <= 1'b0;
			sel_s1   <= 1'b0;
		end else if (out_load) begin
			sel_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			addr_s1    <= base_addr;
			zero_lo_s1 <= (pixel_pair[3:0] == '0);
			zero_hi_s1 <= (pixel_pair[7:4] == '0);
			final_s1   <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q  <= {addr_s1[ADDR_W-1:1], sel_s1};
			out_color_q <= texel_color;
			out_last_q  <= sel_s1;
			out_done_q  <= sel_s1 && final_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - ADDR_W - RGBA_W){1'b0}}, out_color_q, out_addr_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_done_q;

	`ASSERT_SAME(a_done_on_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
		"icon_done on a left texel")
	`ASSERT_NEXT(a_pair_follows, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast,
		"right texel did not follow left texel")
	`ASSERT_NEXT(a_byte_fills, clk, arst_n, byte_take, valid_s1 && !sel_s1,
		"accepted byte did not enter pair stage")
	`ASSERT_SAME(a_cnt_range, clk, arst_n, 1'b1,
		(cnt_q <= CW'(ICON_BYTES - 1)) && (tile_x_q <= TXW'(TILES_X - 1)),
		"byte position out of range")

endmodule

FILE: test/tpimt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpimt_checker
// Watches both streams of the icon texel writer. It keeps its own palette
// and icon byte count, turns every accepted pixel beat into the two texels
// it must produce, and compares each output beat against the oldest of them.
// ----------------------------------------------------------------------------
module tpimt_checker
	import tpimt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  m_axis_tuser,
	output int                    mismatches,
	output int                    texels_pending
);

	localparam int TILES_ACROSS     = ICON_SIZE_DEF / 8;
	localparam int TEX_TILES_ACROSS = TEX_SIZE_DEF / 8;
	localparam int BYTES_PER_ICON   = ICON_SIZE_DEF * ICON_SIZE_DEF / 2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [RGBA_W-1:0] rgba;
		logic              last;
		logic              done;
	} texel_t;

	texel_t             texel_queue[$];
	logic [COLOR_W-1:0] palette_copy [PAL_DEPTH];
	int                 icon_byte_count;

	// index 0 is see-through; others widen each 5-bit channel to 8 bits
	function automatic logic [RGBA_W-1:0] texel_rgba(input logic [IDX_W-1:0] idx);
		logic [COLOR_W-1:0] bgr;
		logic [7:0]         red, green, blue;
		if (idx == '0)
			return RGBA_CLEAR;
		bgr   = palette_copy[idx];
		red   = {bgr[4:0], 3'b000};
		green = {bgr[9:5], 3'b000};
		blue  = {bgr[14:10], 3'b000};
		return {red, green, blue, ALPHA_OPAQUE};
	endfunction

	// Z-order offset inside an 8x8 tile: x bits on even positions
	function automatic logic [5:0] z_offset(input logic [2:0] x, input logic [2:0] y);
		return {y[2], x[2], y[1], x[1], y[0], x[0]};
	endfunction

	task automatic add_pixel_pair(input logic [PAIR_W-1:0] pair);
		int          src_tile, tex_tile, row, col_pair;
		logic [2:0]  px;
		logic [IDX_W-1:0] idx;
		texel_t      t;
		col_pair = icon_byte_count % 4;
		row      = (icon_byte_count / 4) % 8;
		src_tile = icon_byte_count / 32;
		tex_tile = (src_tile / TILES_ACROSS) * TEX_TILES_ACROSS + src_tile % TILES_ACROSS;
		for (int half = 0; half < 2; half++) begin
			px     = 3'(col_pair * 2 + half);
			idx    = half ? pair[7:4] : pair[3:0];
			t.addr = ADDR_W'(tex_tile * 64 + z_offset(px, 3'(row)));
			t.rgba = texel_rgba(idx);
			t.last = (half == 1);
			t.done = (half == 1) && (icon_byte_count == BYTES_PER_ICON - 1);
			texel_queue.push_back(t);
		end
		icon_byte_count = (icon_byte_count == BYTES_PER_ICON - 1) ? 0 : icon_byte_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		texel_t want, got;
		if (!arst_n) begin
			texel_queue.delete();
			icon_byte_count = 0;
			mismatches      = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[11:0], m_axis_tdata[43:12], m_axis_tlast, m_axis_tuser};
				if (texel_queue.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected texel addr=%h rgba=%h last=%b done=%b",
							$realtime, got.addr, got.rgba, got.last, got.done);
					mismatches++;
				end else begin
					want = texel_queue.pop_front();
					if (got.addr !== want.addr || got.rgba !== want.rgba ||
						got.last !== want.last || got.done !== want.done) begin
						if (mismatches < 10)
							$display("%0t: exp %h/%h/%b/%b got %h/%h/%b/%b",
								$realtime, want.addr, want.rgba, want.last, want.done,
								got.addr, got.rgba, got.last, got.done);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (cmd_t'(s_axis_tuser) == CMD_PALETTE)
					palette_copy[s_axis_tdata[3:0]] = s_axis_tdata[18:4];
				else
					add_pixel_pair(s_axis_tdata[26:19]);
			end
		end
		texels_pending = texel_queue.size();
	end

endmodule

FILE: test/tb_tiled_palette_icon_to_morton_texels.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiled_palette_icon_to_morton_texels
// Loads the palette, sends eight hand-picked icon bytes, then 1680 random
// pixel and palette beats in four phases of changing source gaps and sink
// backpressure, running through a few whole icons. Checking is done by
// tpimt_checker; this module drives and reports the verdict.
// ----------------------------------------------------------------------------
module tb_tiled_palette_icon_to_morton_texels
	import tpimt_pkg::*;
;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;

	int mismatches;
	int texels_pending;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	tiled_palette_icon_to_morton_texels DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	tpimt_checker texel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.m_axis_tuser   (m_axis_tuser),
		.mismatches     (mismatches),
		.texels_pending (texels_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_beat(input cmd_t kind, input logic [IDX_W-1:0] idx,
		input logic [COLOR_W-1:0] bgr, input logic [PAIR_W-1:0] pair);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {5'b00000, pair, bgr, idx};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	initial begin
		logic [COLOR_W-1:0] entry_bgr [PAL_DEPTH];
		logic [PAIR_W-1:0]  hand_pairs [8];

		entry_bgr = '{15'h7FFF, 15'h0000, 15'h001F, 15'h03E0, 15'h7C00, 15'h7FFF,
			15'h5555, 15'h2AAA, 15'h0001, 15'h4000, 15'h0421, 15'h7BDE,
			15'h1234, 15'h6DB6, 15'h3E0F, 15'h7FFF};
		hand_pairs = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h10, 8'h01, 8'h5A, 8'hA5};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every palette slot before any pixel can look one up
		for (int i = 0; i < PAL_DEPTH; i++)
			send_beat(CMD_PALETTE, IDX_W'(i), entry_bgr[i], 8'h00);
		foreach (hand_pairs[i])
			send_beat(CMD_PIXELS, 4'h0, 15'h0000, hand_pairs[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
				default: begin src_idle_pct = 9; sink_stall_pct = 9; end
			endcase
			for (int n = 0; n < 420; n++) begin
				if ($urandom_range(99) < 12)
					send_beat(CMD_PALETTE, IDX_W'($urandom_range(15)),
						COLOR_W'($urandom_range(32767)), PAIR_W'($urandom_range(255)));
				else
					send_beat(CMD_PIXELS, IDX_W'($urandom_range(15)),
						COLOR_W'($urandom_range(32767)), PAIR_W'($urandom_range(255)));
			end
		end

		s_axis_tvalid <= 1'b0;
		sink_stall_pct = 0;
		while (texels_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (mismatches == 0 && texels_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/tpimt_pkg.sv
sv/tpimt_ram.sv
sv/tiled_palette_icon_to_morton_texels.sv
test/tpimt_checker.sv
test/tb_tiled_palette_icon_to_morton_texels.sv
